@@ rtl/core/fta_pkg.sv @@
`default_nettype none

package fta_pkg;

  // Defaults
  localparam int TIME_WIDTH_DEF = 32;
  localparam int TICKS_PER_MINUTE = 60;
  localparam int MINUTES_W = 6;
  localparam int LIMIT_W = 12;  // 63 * 60 = 3780 ticks fits
  localparam logic [MINUTES_W-1:0] MAX_FLOW_MIN_RST = 6'd10;
  localparam logic [MINUTES_W-1:0] MAX_NOFLOW_MIN_RST = 6'd20;

  // Status codes
  localparam logic [1:0] ST_NOFLOW = 2'd0;
  localparam logic [1:0] ST_FLOW = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [1:0] ST_UNINIT = 2'd3;

  // Remembered error kinds
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FLOW = 2'd1;
  localparam logic [1:0] ERR_NOFLOW = 2'd2;

  // LED compare values
  localparam logic [7:0] LED_OFF = 8'h00;
  localparam logic [7:0] LED_BLINK = 8'hcf;
  localparam logic [7:0] LED_ON = 8'hff;

  // Configuration register indexes
  localparam logic REG_MAX_FLOW = 1'b0;
  localparam logic REG_MAX_NOFLOW = 1'b1;

  // Input item action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic action;
    logic flow_sensed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] led_duty;
    logic [1:0] error_kind;
  } out_item_t;

  typedef struct packed {
    logic [1:0] current_status;
    logic [1:0] prior_status;
    logic [1:0] error_memory;
  } fsm_state_t;

  // Minutes to ticks: m * 60 = m * 64 - m * 4
  function automatic logic [LIMIT_W-1:0] minutes_to_ticks(input logic [MINUTES_W-1:0] m);
    return {m, 6'b0} - {4'b0, m, 2'b0};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/flow_timeout_alarm_fsm_core.sv @@
`default_nettype none

// Flow timeout alarm core.
// Input channel (in_valid/in_ready/in_item): one item per sensor tick.
//   action = tick carries a flow sample and yields exactly one result item;
//   action = restart clears the tick counter, flow times and status and
//   yields nothing. Limit registers are kept across a restart.
// Output channel (out_valid/out_ready/out_item): status, LED duty and the
//   remembered error kind for each tick.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 = flow limit minutes,
//   index 1 = no-flow limit minutes. Write only while the block is idle.
// Pipeline: an accepted tick passes the input register, then the result
//   register, which raises out_valid. Throughput: one item per cycle while
//   out_ready stays high; the status update and the single elapsed-time
//   compare are combinational.
// Stall: when out_ready is low the result register holds its item; the
//   input register still fills, and in_ready drops only once both are full.
//   Restart items drain from the input register even during a stall.
// Reset (rst, synchronous): both stages empty, status uninitialized,
//   counters zero, limits back to 10 and 20 minutes.
module flow_timeout_alarm_fsm_core #(
  parameter int TIME_WIDTH = fta_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fta_pkg::in_item_t    in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fta_pkg::out_item_t        out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [fta_pkg::MINUTES_W-1:0] cfg_wdata
);
  import fta_pkg::*;

  // Limits kept in ticks so the compare needs no divide
  logic [LIMIT_W-1:0]    flow_limit;
  logic [LIMIT_W-1:0]    noflow_limit;

  // Input stage
  logic                  in_v;
  in_item_t              in_q;

  // Block state
  logic [TIME_WIDTH-1:0] tick_count;
  logic [TIME_WIDTH-1:0] flow_start_tick;
  logic [TIME_WIDTH-1:0] flow_end_tick;
  fsm_state_t            st;

  // Step logic outputs
  fsm_state_t            st_next;
  logic [TIME_WIDTH-1:0] flow_start_next;
  logic [TIME_WIDTH-1:0] flow_end_next;
  out_item_t             result;

  logic                  is_restart;
  logic                  out_free;
  logic                  fire;

  assign is_restart = (in_q.action == ACT_RESTART);
  assign out_free   = !out_valid || out_ready;
  // A restart needs no result slot; a tick needs a free result register
  assign fire       = in_v && (is_restart || out_free);
  assign in_ready   = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_limit   <= minutes_to_ticks(MAX_FLOW_MIN_RST);
      noflow_limit <= minutes_to_ticks(MAX_NOFLOW_MIN_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FLOW:   flow_limit   <= minutes_to_ticks(cfg_wdata);
        REG_MAX_NOFLOW: noflow_limit <= minutes_to_ticks(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  fta_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .flow_sensed     (in_q.flow_sensed),
    .tick_count      (tick_count),
    .flow_start_tick (flow_start_tick),
    .flow_end_tick   (flow_end_tick),
    .st              (st),
    .flow_limit      (flow_limit),
    .noflow_limit    (noflow_limit),
    .st_next         (st_next),
    .flow_start_next (flow_start_next),
    .flow_end_next   (flow_end_next),
    .result          (result)
  );

  // State update: restart clears, a tick advances the machine and counter
  always_ff @(posedge clk) begin
    if (rst || (fire && is_restart)) begin
      tick_count        <= '0;
      flow_start_tick   <= '0;
      flow_end_tick     <= '0;
      st.current_status <= ST_UNINIT;
      st.prior_status   <= ST_NOFLOW;
      st.error_memory   <= ERR_NONE;
    end else if (fire) begin
      tick_count      <= tick_count + 1'b1;
      flow_start_tick <= flow_start_next;
      flow_end_tick   <= flow_end_next;
      st              <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && !is_restart) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_restart) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fta_step.sv @@
`default_nettype none

module fta_step #(
  parameter int TIME_WIDTH = fta_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                    flow_sensed,
  input  wire logic [TIME_WIDTH-1:0]   tick_count,
  input  wire logic [TIME_WIDTH-1:0]   flow_start_tick,
  input  wire logic [TIME_WIDTH-1:0]   flow_end_tick,
  input  wire fta_pkg::fsm_state_t     st,
  input  wire logic [fta_pkg::LIMIT_W-1:0] flow_limit,
  input  wire logic [fta_pkg::LIMIT_W-1:0] noflow_limit,
  output fta_pkg::fsm_state_t          st_next,
  output logic [TIME_WIDTH-1:0]        flow_start_next,
  output logic [TIME_WIDTH-1:0]        flow_end_next,
  output fta_pkg::out_item_t           result
);
  import fta_pkg::*;

  logic [TIME_WIDTH-1:0] ref_tick;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [LIMIT_W-1:0]    limit;
  logic                  expired;
  logic                  move;
  logic [1:0]            target;
  logic                  err_seen;
  logic                  noflow_seen;

  // One subtract/compare shared by both timed states
  assign ref_tick = (st.current_status == ST_FLOW) ? flow_start_tick : flow_end_tick;
  assign limit    = (st.current_status == ST_FLOW) ? flow_limit : noflow_limit;
  assign elapsed  = tick_count - ref_tick;
  assign expired  = elapsed >= TIME_WIDTH'(limit);

  always_comb begin
    flow_start_next      = flow_start_tick;
    flow_end_next        = flow_end_tick;
    st_next              = st;
    move                 = 1'b0;
    target               = st.current_status;
    unique case (st.current_status)
      ST_UNINIT: begin
        move = 1'b1;
        if (flow_sensed) begin
          flow_start_next = tick_count;
          target          = ST_FLOW;
        end else begin
          flow_end_next = tick_count;
          target        = ST_NOFLOW;
        end
      end
      ST_NOFLOW: begin
        if (flow_sensed) begin
          flow_start_next = tick_count;
          move            = 1'b1;
          target          = ST_FLOW;
        end else if (expired) begin
          move   = 1'b1;
          target = ST_ERROR;
        end
      end
      ST_FLOW: begin
        if (!flow_sensed) begin
          flow_end_next = tick_count;
          move          = 1'b1;
          target        = ST_NOFLOW;
        end else if (expired) begin
          move   = 1'b1;
          target = ST_ERROR;
        end
      end
      default: begin
        move = 1'b1;
        if (st.prior_status == ST_FLOW) begin
          st_next.error_memory = ERR_FLOW;
          target               = ST_FLOW;
        end else begin
          st_next.error_memory = ERR_NOFLOW;
          target               = ST_NOFLOW;
        end
      end
    endcase
    if (move) begin
      st_next.prior_status   = st.current_status;
      st_next.current_status = target;
    end
  end

  // LED duty from the updated status pair and error memory
  assign err_seen    = (st_next.current_status == ST_ERROR) ||
                       (st_next.prior_status == ST_ERROR);
  assign noflow_seen = (st_next.current_status == ST_NOFLOW) ||
                       (st_next.prior_status == ST_NOFLOW);

  always_comb begin
    result.status     = st_next.current_status;
    result.error_kind = st_next.error_memory;
    if (err_seen) begin
      result.led_duty = noflow_seen ? LED_BLINK : LED_ON;
    end else begin
      case (st_next.error_memory)
        ERR_NONE: result.led_duty = LED_OFF;
        ERR_FLOW: result.led_duty = LED_ON;
        default:  result.led_duty = LED_BLINK;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
  import fta_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LONG_HOLD = 64;       // receiver hold-off, cycles
  localparam int SETTLE_CYCLES = 4;    // covers the two-stage pipe
  localparam int DIR_ROWS = 22;
  localparam int ROW_ZERO_LIMITS = 3;  // limits go to 0/0 before this row

  // One directed row: action, sensor bit, whether the expected result
  // below is typed in, and that result ({status, led, error kind}).
  typedef struct packed {
    logic      act;
    logic      flow;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  // Rows 0..2 run under the reset limits (10/20); the rest under 0/0 so
  // that every alarm path fires on the first checked tick.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_OFF,   ERR_NONE}},
    '{ACT_TICK,    1'b1, 1'b1, {ST_FLOW,   LED_OFF,   ERR_NONE}},
    '{ACT_RESTART, 1'b1, 1'b0, 12'h000},
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_OFF,   ERR_NONE}},
    '{ACT_TICK,    1'b0, 1'b1, {ST_ERROR,  LED_BLINK, ERR_NONE}},
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_BLINK, ERR_NOFLOW}},
    '{ACT_TICK,    1'b1, 1'b1, {ST_FLOW,   LED_BLINK, ERR_NOFLOW}},
    '{ACT_TICK,    1'b1, 1'b1, {ST_ERROR,  LED_ON,    ERR_NOFLOW}},
    '{ACT_TICK,    1'b1, 1'b1, {ST_FLOW,   LED_ON,    ERR_FLOW}},
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_ON,    ERR_FLOW}},
    '{ACT_TICK,    1'b0, 1'b0, 12'h000},
    '{ACT_TICK,    1'b1, 1'b0, 12'h000},
    '{ACT_RESTART, 1'b0, 1'b0, 12'h000},
    '{ACT_TICK,    1'b1, 1'b1, {ST_FLOW,   LED_OFF,   ERR_NONE}},
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_OFF,   ERR_NONE}},
    '{ACT_TICK,    1'b0, 1'b1, {ST_ERROR,  LED_BLINK, ERR_NONE}},
    // sensor is ignored while in error: back to no flow
    '{ACT_TICK,    1'b1, 1'b1, {ST_NOFLOW, LED_BLINK, ERR_NOFLOW}},
    '{ACT_RESTART, 1'b0, 1'b0, 12'h000},
    '{ACT_RESTART, 1'b1, 1'b0, 12'h000},
    '{ACT_TICK,    1'b0, 1'b1, {ST_NOFLOW, LED_OFF,   ERR_NONE}},
    '{ACT_TICK,    1'b1, 1'b0, 12'h000},
    '{ACT_TICK,    1'b1, 1'b0, 12'h000}
  };

  // Limit pairs for the random phases, extremes included.
  logic [MINUTES_W-1:0] phase_flow_lim   [RANDOM_PHASES] =
    '{6'd1, 6'd63, 6'd0, 6'd2, 6'd1, 6'd10, 6'd0};
  logic [MINUTES_W-1:0] phase_noflow_lim [RANDOM_PHASES] =
    '{6'd2, 6'd0, 6'd63, 6'd1, 6'd1, 6'd20, 6'd63};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_index = REG_MAX_FLOW;
  logic [MINUTES_W-1:0] cfg_wdata = '0;

  // Shadow of the alarm machine, advanced at each accepted item.
  logic [TW-1:0]        tick_now = '0;
  logic [TW-1:0]        flow_start = '0;
  logic [TW-1:0]        flow_end = '0;
  logic [1:0]           cur_st = ST_UNINIT;
  logic [1:0]           prior_st = ST_NOFLOW;
  logic [1:0]           err_mem = ERR_NONE;
  logic [MINUTES_W-1:0] flow_lim = MAX_FLOW_MIN_RST;
  logic [MINUTES_W-1:0] noflow_lim = MAX_NOFLOW_MIN_RST;

  out_item_t expected_status_q [$];
  out_item_t want;

  int mismatch_count = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int restarts_sent = 0;
  int alarms_seen = 0;
  int limit_settings = 0;
  bit long_hold_done = 1'b0;

  flow_timeout_alarm_fsm_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Safety net: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got,
             exp_val);
  endtask

  // Advance the alarm machine by one item; a restart yields no result.
  task automatic alarm_step(input in_item_t it, output bit has_res, output out_item_t res);
    logic [1:0]    nxt;
    logic [TW-1:0] span;
    has_res = 1'b0;
    res = '0;
    if (it.action == ACT_RESTART) begin
      tick_now = '0;
      flow_start = '0;
      flow_end = '0;
      cur_st = ST_UNINIT;
      prior_st = ST_NOFLOW;
      err_mem = ERR_NONE;
      return;
    end
    nxt = cur_st;
    case (cur_st)
      ST_UNINIT, ST_NOFLOW: begin
        span = tick_now - flow_end;
        if (it.flow_sensed) begin
          flow_start = tick_now;
          nxt = ST_FLOW;
        end else if (cur_st == ST_UNINIT) begin
          flow_end = tick_now;
          nxt = ST_NOFLOW;
        end else if (span / TICKS_PER_MINUTE >= TW'(noflow_lim)) begin
          nxt = ST_ERROR;
        end
      end
      ST_FLOW: begin
        span = tick_now - flow_start;
        if (!it.flow_sensed) begin
          flow_end = tick_now;
          nxt = ST_NOFLOW;
        end else if (span / TICKS_PER_MINUTE >= TW'(flow_lim)) begin
          nxt = ST_ERROR;
        end
      end
      default: begin
        // one tick in error, then back to where the alarm came from
        err_mem = (prior_st == ST_FLOW) ? ERR_FLOW : ERR_NOFLOW;
        nxt = (prior_st == ST_FLOW) ? ST_FLOW : ST_NOFLOW;
      end
    endcase
    if (nxt != cur_st) begin
      prior_st = cur_st;
      cur_st = nxt;
    end
    res.status = cur_st;
    res.error_kind = err_mem;
    if (cur_st == ST_ERROR || prior_st == ST_ERROR)
      res.led_duty = (cur_st == ST_NOFLOW || prior_st == ST_NOFLOW) ? LED_BLINK : LED_ON;
    else if (err_mem == ERR_NONE)
      res.led_duty = LED_OFF;
    else
      res.led_duty = (err_mem == ERR_FLOW) ? LED_ON : LED_BLINK;
    tick_now = tick_now + 1'b1;
    has_res = 1'b1;
  endtask

  // Offer one item at the falling edge, hold it until taken, then predict.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    bit        has_res;
    out_item_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    alarm_step(it, has_res, res);
    if (it.action == ACT_RESTART) restarts_sent++;
    else ticks_sent++;
    if (has_res) expected_status_q.push_back(typed ? typed_res : res);
  endtask

  // Sender idle gap: mostly none or short, now and then long.
  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 65) return;
    n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Limits change only with the pipe empty; a trailing restart leaves no
  // result behind, so let the pipe settle after the queue drains.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(input logic [MINUTES_W-1:0] f_lim,
                              input logic [MINUTES_W-1:0] nf_lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_FLOW;
    cfg_wdata <= f_lim;
    @(negedge clk);
    cfg_index <= REG_MAX_NOFLOW;
    cfg_wdata <= nf_lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    flow_lim = f_lim;
    noflow_lim = nf_lim;
    limit_settings++;
  endtask

  // Receiver: ready stretches broken by stalls; one long hold-off once
  // the random traffic is under way, so the input side backs up.
  initial begin
    int unsigned on_len;
    int unsigned off_len;
    int unsigned r;
    @(negedge clk);
    forever begin
      on_len = $urandom_range(1, 24);
      r = $urandom_range(99);
      if (r < 20) off_len = 0;
      else if (r < 92) off_len = $urandom_range(1, 3);
      else off_len = $urandom_range(10, 40);
      if (!long_hold_done && ticks_sent >= 300) begin
        off_len = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      out_ready <= 1'b1;
      repeat (on_len) @(negedge clk);
      if (off_len != 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_item.status == ST_ERROR) alarms_seen++;
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected item", int'(out_item), 0);
      end else begin
        want = expected_status_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.led_duty !== want.led_duty)
          report_mismatch("led_duty", out_item.led_duty, want.led_duty);
        if (out_item.error_kind !== want.error_kind)
          report_mismatch("error_kind", out_item.error_kind, want.error_kind);
      end
    end
  end

  initial begin
    in_item_t    it;
    int unsigned run_len;
    int unsigned sent;
    bit          run_flow;
    bit          noisy;
    bit          burst;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == ROW_ZERO_LIMITS) begin
        drain_and_settle();
        write_limits('0, '0);
      end
      it.action = dir_rows[i].act;
      it.flow_sensed = dir_rows[i].flow;
      send_item(it, dir_rows[i].typed, dir_rows[i].res);
      sender_gap();
    end

    // Random phases: runs of steady flow or no flow, some long enough to cross
    // the shorter minute limits, some noisy runs, the odd restart.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_and_settle();
      write_limits(phase_flow_lim[p], phase_noflow_lim[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 4) begin
          it.action = ACT_RESTART;
          it.flow_sensed = 1'($urandom_range(1));
          send_item(it, 1'b0, '0);
          sent++;
        end
        run_len = ($urandom_range(99) < 65) ? $urandom_range(1, 10) : $urandom_range(30, 160);
        run_flow = 1'($urandom_range(1));
        noisy = ($urandom_range(99) < 20);
        burst = ($urandom_range(99) < 25);
        for (int k = 0; k < run_len && sent < ITEMS_PER_PHASE; k++) begin
          it.action = ACT_TICK;
          it.flow_sensed = noisy ? 1'($urandom_range(1)) : run_flow;
          send_item(it, 1'b0, '0);
          sent++;
          if (!burst) sender_gap();
        end
      end
    end

    drain_and_settle();
    repeat (8) @(negedge clk);

    $display("ran %0d ticks and %0d restarts; %0d results checked, %0d alarm ticks",
             ticks_sent, restarts_sent, results_seen, alarms_seen);
    $display("%0d limit settings including 0 and 63 minutes, one %0d-cycle output hold-off",
             limit_settings, LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
